// File: hw/rtl/rbl_pkg.sv
package rbl_pkg;

	localparam int DATA_W = 64;
	localparam int KIND_W = 4;
	localparam int MODE_W = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COMMIT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIMIT   = 3'd4;

	localparam logic [KIND_W-1:0] CUM_KIND_RESET = 4'd5;

	typedef enum logic [2:0] {
		OP_RESERVE = 3'd0,
		OP_RELEASE = 3'd1,
		OP_COMMIT  = 3'd2,
		OP_READ    = 3'd3,
		OP_LIMIT   = 3'd4,
		OP_BAD     = 3'd5
	} op_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] amount;
		logic [DATA_W-1:0] used;
		logic              cancel;
	} in_item_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] reserved_total;
		logic [DATA_W-1:0] committed_total;
		logic [DATA_W-1:0] peak_total;
		logic [DATA_W-1:0] cumulative_total;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] amount;
		logic [DATA_W-1:0] used;
		logic              cancel;
	} cmd_t;

endpackage

// File: hw/rtl/resource_budget_ledger.sv
// path: an accepted item passes through a queue slot, the read registers and the output register
// rate: a command leaves the queue only after the read then execute pass over the
// ledger register file for the last one; the command queue holds up to two items more
// reset: all counters and hard limits clear to zero, cumulative kind returns to 5,
// queue and output register empty
module resource_budget_ledger #(
	parameter int NUM_KINDS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rbl_pkg::in_item_t          in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rbl_pkg::out_item_t         out_item,
	input  logic                       cfg_we,
	input  logic [rbl_pkg::KIND_W-1:0] cfg_wdata
);
	import rbl_pkg::*;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	cmd_t              push_cmd;
	cmd_t              pop_cmd;
	logic [KIND_W-1:0] cum_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_kind_q <= CUM_KIND_RESET;
		end else if (cfg_we) begin
			cum_kind_q <= cfg_wdata;
		end
	end

	rbl_front #(
		.NUM_KINDS(NUM_KINDS)
	) u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd)
	);

	rbl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (pop_cmd),
		.empty   (q_empty)
	);

	rbl_back #(
		.NUM_KINDS(NUM_KINDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cum_kind (cum_kind_q),
		.q_empty  (q_empty),
		.q_cmd    (pop_cmd),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

`ifndef NO_ASSERTIONS
	// a new result only appears once a command popped from the queue has passed the execute state
	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop, 2))
		else $error("result appeared without a queued command");

	// the back end never pops while the output slot is still occupied
	a_pop_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || out_ready))
		else $error("command popped with the output slot busy");

	// a transfer into an empty queue must leave it non-empty
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && q_empty) |=> !q_empty)
		else $error("accepted item lost before the back end");
`endif

endmodule

// File: hw/rtl/rbl_front.sv
module rbl_front #(
	parameter int NUM_KINDS = 12
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  rbl_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              q_push,
	output rbl_pkg::cmd_t     q_cmd
);
	import rbl_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.kind   = in_item.kind;
		q_cmd.amount = in_item.amount;
		q_cmd.used   = in_item.used;
		q_cmd.cancel = in_item.cancel;
		priority if ({1'b0, in_item.kind} >= (KIND_W + 1)'(NUM_KINDS)) begin
			q_cmd.op = OP_BAD;
		end else begin
			// unused mode codes behave like a read
			unique case (in_item.mode)
				MODE_RESERVE: q_cmd.op = OP_RESERVE;
				MODE_RELEASE: q_cmd.op = OP_RELEASE;
				MODE_COMMIT:  q_cmd.op = OP_COMMIT;
				MODE_READ:    q_cmd.op = OP_READ;
				MODE_LIMIT:   q_cmd.op = OP_LIMIT;
				default:      q_cmd.op = OP_READ;
			endcase
		end
	end

endmodule

// File: hw/rtl/rbl_queue.sv
module rbl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rbl_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output rbl_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import rbl_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hw/rtl/rbl_back.sv
module rbl_back #(
	parameter int NUM_KINDS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rbl_pkg::KIND_W-1:0] cum_kind,
	input  logic                       q_empty,
	input  rbl_pkg::cmd_t              q_cmd,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rbl_pkg::out_item_t         out_item
);
	import rbl_pkg::*;

	localparam int KW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] res_q  [NUM_KINDS];
	logic [DATA_W-1:0] com_q  [NUM_KINDS];
	logic [DATA_W-1:0] peak_q [NUM_KINDS];
	logic [DATA_W-1:0] cum_q  [NUM_KINDS];
	logic [DATA_W-1:0] lim_q  [NUM_KINDS];

	cmd_t              cmd_s1;
	logic [DATA_W-1:0] res_s1;
	logic [DATA_W-1:0] com_s1;
	logic [DATA_W-1:0] peak_s1;
	logic [DATA_W-1:0] cum_s1;
	logic [DATA_W-1:0] lim_s1;
	logic [DATA_W:0]   live_s1;

	logic              out_valid_q;
	out_item_t         out_item_q;

	logic [KW-1:0]     rd_idx;
	logic [KW-1:0]     wr_idx;
	logic [DATA_W:0]   next_sum;
	logic [DATA_W:0]   rel_diff;
	logic [DATA_W-1:0] res_n;
	logic [DATA_W-1:0] com_n;
	logic [DATA_W-1:0] peak_n;
	logic [DATA_W-1:0] cum_n;
	logic [DATA_W-1:0] lim_n;
	logic              ok_n;
	logic              wr_en;
	out_item_t         result;

	assign rd_idx    = q_cmd.kind[KW-1:0];
	assign wr_idx    = cmd_s1.kind[KW-1:0];
	// output slot is free for the whole read/execute pass once a pop happens
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		next_sum = {1'b0, live_s1[DATA_W-1:0]} + {1'b0, cmd_s1.amount};
		rel_diff = {1'b0, res_s1} - {1'b0, cmd_s1.amount};
		res_n    = res_s1;
		com_n    = com_s1;
		peak_n   = peak_s1;
		cum_n    = cum_s1;
		lim_n    = lim_s1;
		ok_n     = 1'b1;
		wr_en    = 1'b0;
		unique case (cmd_s1.op)
			OP_RESERVE: begin
				if (!cmd_s1.cancel && !live_s1[DATA_W] && !next_sum[DATA_W]
						&& (next_sum[DATA_W-1:0] <= lim_s1)) begin
					res_n = res_s1 + cmd_s1.amount;
					if (next_sum[DATA_W-1:0] > peak_s1) begin
						peak_n = next_sum[DATA_W-1:0];
					end
					if (cmd_s1.kind == cum_kind) begin
						cum_n = cum_s1 + cmd_s1.amount;
					end
					wr_en = 1'b1;
				end else begin
					ok_n = 1'b0;
				end
			end
			OP_RELEASE: begin
				// saturate at zero on borrow
				res_n = rel_diff[DATA_W] ? '0 : rel_diff[DATA_W-1:0];
				wr_en = 1'b1;
			end
			OP_COMMIT: begin
				if ((cmd_s1.used <= cmd_s1.amount) && (cmd_s1.amount <= res_s1)) begin
					res_n = res_s1 - cmd_s1.amount;
					com_n = com_s1 + cmd_s1.used;
					wr_en = 1'b1;
				end else begin
					ok_n = 1'b0;
				end
			end
			OP_LIMIT: begin
				lim_n = cmd_s1.amount;
				wr_en = 1'b1;
			end
			OP_READ: begin
			end
			OP_BAD: begin
				ok_n = 1'b0;
			end
			default: begin
			end
		endcase

		if (cmd_s1.op == OP_BAD) begin
			result = '0;
		end else begin
			result.ok               = ok_n;
			result.reserved_total   = res_n;
			result.committed_total  = com_n;
			result.peak_total       = peak_n;
			result.cumulative_total = cum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_KINDS; i++) begin
				res_q[i]  <= '0;
				com_q[i]  <= '0;
				peak_q[i] <= '0;
				cum_q[i]  <= '0;
				lim_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if (wr_en) begin
						res_q[wr_idx]  <= res_n;
						com_q[wr_idx]  <= com_n;
						peak_q[wr_idx] <= peak_n;
						cum_q[wr_idx]  <= cum_n;
						lim_q[wr_idx]  <= lim_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1  <= q_cmd;
			res_s1  <= res_q[rd_idx];
			com_s1  <= com_q[rd_idx];
			peak_s1 <= peak_q[rd_idx];
			cum_s1  <= cum_q[rd_idx];
			lim_s1  <= lim_q[rd_idx];
			live_s1 <= {1'b0, res_q[rd_idx]} + {1'b0, com_q[rd_idx]};
		end
		if (state_q == ST_EXEC) begin
			out_item_q <= result;
		end
	end

endmodule
